// File: rtl/plft_pkg.sv
// Package: shared constants, types, op codes and register indices for the phase lock frequency tracker.
`timescale 1ns / 1ps
`default_nettype none
package plft_pkg;

  localparam int HISTORY_DEPTH_DEF      = 8;
  localparam int NOISE_DIVISOR_DEF      = 20;
  localparam int REJECT_LIMIT_DEF       = 50;
  localparam int UPDATE_INTERVAL_MS_DEF = 10;
  localparam int ACQUIRE_OFFSET_HZ_DEF  = 2000;
  localparam int CREEP_STEP_HZ_DEF      = 15;

  localparam logic [1:0] OP_CAPTURE = 2'd0;
  localparam logic [1:0] OP_ENGAGE  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_DEADBAND = 3'd1;
  localparam logic [2:0] REG_JUMP     = 3'd2;
  localparam logic [2:0] REG_GAIN     = 3'd3;
  localparam logic [2:0] REG_MAX_STEP = 3'd4;
  localparam logic [2:0] REG_MIN_FREQ = 3'd5;
  localparam logic [2:0] REG_MAX_FREQ = 3'd6;
  localparam logic [2:0] REG_START    = 3'd7;

  localparam int CFG_W = 24;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/plft_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plft_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plft_pkg::div_req_t req,
  output plft_pkg::div_rsp_t      rsp
);

  logic [32:0] quo;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, quotient: quo};

endmodule
`default_nettype wire

// File: rtl/phase_lock_frequency_tracker.sv
// Top level: sequencer, history averaging and frequency loop around a serial divider.
// Flow: engage/release/op 3 go from acceptance straight to the result register; an
// untracked capture adds the 33-step serial phase divide; a tracked capture adds the
// history sum, average, gain multiply and step, plus a prime state when it is refilled.
// Throughput: one item at a time; s_tready is low while an item is in work or its
// result has not been taken.
// Reset: synchronous, active high; registers return to their reset values.
`timescale 1ns / 1ps
`default_nettype none
module phase_lock_frequency_tracker #(
  parameter int HISTORY_DEPTH      = plft_pkg::HISTORY_DEPTH_DEF,
  parameter int NOISE_DIVISOR      = plft_pkg::NOISE_DIVISOR_DEF,
  parameter int REJECT_LIMIT       = plft_pkg::REJECT_LIMIT_DEF,
  parameter int UPDATE_INTERVAL_MS = plft_pkg::UPDATE_INTERVAL_MS_DEF,
  parameter int ACQUIRE_OFFSET_HZ  = plft_pkg::ACQUIRE_OFFSET_HZ_DEF,
  parameter int CREEP_STEP_HZ      = plft_pkg::CREEP_STEP_HZ_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [plft_pkg::CFG_W-1:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op[1:0], capture_count[17:2], period_count[34:18], compare_point[50:35],
  // lock_enable[51], pwm_on[52], time_ms[84:53], zero fill to 88
  input  wire logic [87:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // drive_freq[19:0], freq_write[20], phase_meas[36:21], phase_ok[37],
  // in_deadband[38], lock_freq[58:39], reacquired[59], tracking[60], zero fill to 64
  output logic [63:0]      m_tdata
);

  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SW = 18 + HW + 1;
  // reciprocal for the noise margin, exact for any 17-bit period
  localparam int     NK = 17 + $clog2(NOISE_DIVISOR);
  localparam longint NM = ((64'd1 << NK) + NOISE_DIVISOR - 1) / NOISE_DIVISOR;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIVW  = 9'b000000010,
    S_PHASE = 9'b000000100,
    S_PRIME = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_AVG   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_STEP  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic signed [15:0] target;
  logic [14:0] deadband, jump;
  logic [15:0] gain;
  logic [23:0] step_lim;
  logic [19:0] min_f, max_f, start_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0; deadband <= 15'd182; jump <= 15'd21845; gain <= 16'd256;
      step_lim <= 24'd25600; min_f <= 20'd15000; max_f <= 20'd100000;
      start_f <= 20'd30000;
    end else if (cfg_we) begin
      case (cfg_index)
        plft_pkg::REG_TARGET:   target   <= cfg_data[15:0];
        plft_pkg::REG_DEADBAND: deadband <= cfg_data[14:0];
        plft_pkg::REG_JUMP:     jump     <= cfg_data[14:0];
        plft_pkg::REG_GAIN:     gain     <= cfg_data[15:0];
        plft_pkg::REG_MAX_STEP: step_lim <= cfg_data;
        plft_pkg::REG_MIN_FREQ: min_f    <= cfg_data[19:0];
        plft_pkg::REG_MAX_FREQ: max_f    <= cfg_data[19:0];
        plft_pkg::REG_START:    start_f  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [15:0] cnt_in;
  logic [16:0] period;
  logic [15:0] cmp;
  logic        en, pwm;
  logic [31:0] now;

  // block state
  logic signed [17:0] hist [HISTORY_DEPTH];
  logic [HW-1:0] hidx;
  logic        primed;
  logic signed [17:0] prev_fp;
  logic [15:0] rejects;
  logic [27:0] acc;
  logic [19:0] cur_f, lock_f;
  logic        locked, dbf;
  logic [31:0] last_ms;
  logic signed [15:0] last_ph;

  // per-item
  logic wr, ok, reacq;
  logic signed [17:0] absph;
  logic signed [SW-1:0] sum;
  logic [HW:0] sidx;
  logic signed [17:0] fp, err;
  logic signed [33:0] prod;

  // divider
  plft_pkg::div_req_t dreq;
  plft_pkg::div_rsp_t drsp;
  plft_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // noise window (margin = period / NOISE_DIVISOR via reciprocal multiply)
  logic [16:0] margin;
  logic [35:0] mprod;
  logic signed [18:0] c_s, p_s, m_s, cmp_s;
  logic ok_c, due;
  assign mprod = 36'(period) * 36'(NM);
  assign margin = 17'(mprod >> NK);
  assign c_s = 19'(cnt_in);
  assign p_s = 19'(period);
  assign m_s = 19'(margin);
  assign cmp_s = 19'(cmp);
  assign ok_c = (period != 17'd0) &&
                !((c_s < m_s) || (c_s > p_s - m_s)) &&
                !((c_s > cmp_s - m_s) && (c_s < cmp_s + m_s));
  assign due = (now - last_ms) >= 32'(UPDATE_INTERVAL_MS);

  // phase wrap relative to target
  logic [15:0] ph16, rel16;
  logic signed [17:0] rel;
  assign ph16  = drsp.quotient[15:0];
  assign rel16 = ph16 - target;
  assign rel   = (rel16 == 16'h8000) ? 18'sd32768 : 18'(signed'(rel16));

  // jump and error
  logic [15:0] jd16, er16;
  logic signed [16:0] jd, erw;
  logic [16:0] jabs, eabs;
  assign jd16 = fp[15:0] - prev_fp[15:0];
  assign jd   = 17'(signed'(jd16));
  assign jabs = jd[16] ? 17'(-jd) : 17'(jd);
  assign er16 = fp[15:0] - target;
  assign erw  = 17'(signed'(er16));
  assign eabs = erw[16] ? 17'(-erw) : 17'(erw);

  // engage frequency
  logic [20:0] fa_raw;
  logic [19:0] fa;
  assign fa_raw = 21'(lock_f != 20'd0 ? lock_f : start_f) + 21'(ACQUIRE_OFFSET_HZ);
  assign fa = (fa_raw > 21'(max_f)) ? max_f : fa_raw[19:0];

  // step from registered product, truncated toward zero
  logic signed [33:0] negp;
  logic signed [18:0] stepq;
  logic signed [25:0] step_c;
  logic signed [25:0] lim_s;
  logic signed [29:0] lo_s, hi_s;
  logic signed [29:0] acc_n;
  logic [27:0] acc_c;
  logic [19:0] nf_step;
  assign negp = -prod;
  assign stepq = negp[33] ? 19'(-((-negp) >>> 16)) : 19'(negp >>> 16);
  assign lim_s = signed'({2'b00, step_lim});
  assign lo_s  = signed'({2'b00, min_f, 8'd0});
  assign hi_s  = signed'({2'b00, max_f, 8'd0});
  always_comb begin
    step_c = 26'(stepq);
    if (step_c > lim_s) step_c = lim_s;
    if (step_c < -lim_s) step_c = -lim_s;
    acc_n = signed'({2'b00, acc}) + 30'(step_c);
    if (acc_n < lo_s) acc_n = lo_s;
    if (acc_n > hi_s) acc_n = hi_s;
    acc_c = acc_n[27:0];
    nf_step = 20'((29'(acc_c) + 29'd128) >> 8);
  end

  // creep
  logic [28:0] acc_cr;
  logic [19:0] nf_cr;
  assign acc_cr = 29'(acc) + 29'(CREEP_STEP_HZ * 256);
  assign nf_cr = 20'((30'(acc_cr) + 30'd128) >> 8);
  logic cr_over;
  assign cr_over = ((30'(acc_cr) + 30'd128) >> 8) > 30'(max_f);

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; dreq.start <= 1'b0;
      hidx <= '0; primed <= 1'b0; prev_fp <= '0; rejects <= '0;
      acc <= {20'd30000, 8'd0}; cur_f <= 20'd30000; lock_f <= '0;
      locked <= 1'b0; dbf <= 1'b0; last_ms <= '0; last_ph <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
    end else begin
      dreq.start <= (state == S_IDLE) && s_tvalid && s_tready &&
                    (s_tdata[1:0] == plft_pkg::OP_CAPTURE);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          cnt_in <= s_tdata[17:2]; period <= s_tdata[34:18];
          cmp <= s_tdata[50:35]; en <= s_tdata[51]; pwm <= s_tdata[52];
          now <= s_tdata[84:53];
          wr <= (s_tdata[1:0] == plft_pkg::OP_ENGAGE); ok <= 1'b0; reacq <= 1'b0;
          if (s_tdata[1:0] == plft_pkg::OP_ENGAGE) begin
            locked <= 1'b1; hidx <= '0; primed <= 1'b0;
            dbf <= 1'b0; rejects <= '0; prev_fp <= 18'(target);
            cur_f <= (21'(lock_f != 20'd0 ? lock_f : start_f) +
                      21'(ACQUIRE_OFFSET_HZ) > 21'(max_f)) ? max_f :
                     20'(21'(lock_f != 20'd0 ? lock_f : start_f) + 21'(ACQUIRE_OFFSET_HZ));
            acc <= {(21'(lock_f != 20'd0 ? lock_f : start_f) +
                     21'(ACQUIRE_OFFSET_HZ) > 21'(max_f)) ? max_f :
                    20'(21'(lock_f != 20'd0 ? lock_f : start_f) + 21'(ACQUIRE_OFFSET_HZ)),
                    8'd0};
            state <= S_OUT;
          end else if (s_tdata[1:0] == plft_pkg::OP_RELEASE) begin
            locked <= 1'b0; dbf <= 1'b0; rejects <= '0; lock_f <= '0;
            acc <= {cur_f, 8'd0};
            state <= S_OUT;
          end else if (s_tdata[1:0] == plft_pkg::OP_CAPTURE) begin
            dreq.dividend <= {1'b0, s_tdata[17:2], 16'd0} + 33'(s_tdata[34:19]);
            dreq.divisor  <= s_tdata[34:18];
            state <= S_DIVW;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIVW: if (drsp.done) state <= S_PHASE;
        S_PHASE: begin
          ok <= ok_c;
          absph <= 18'(target) + rel;
          if (ok_c) last_ph <= target + rel[15:0];
          if (locked && en && pwm) begin
            if (!ok_c) begin
              if (rejects != 16'hFFFF) rejects <= rejects + 16'd1;
              if (17'(rejects) + 17'd1 > 17'(REJECT_LIMIT)) begin
                acc <= cr_over ? {max_f, 8'd0} : acc_cr[27:0];
                if (due) begin
                  cur_f <= cr_over ? max_f : nf_cr;
                  wr <= 1'b1; last_ms <= now;
                end
              end
              state <= S_OUT;
            end else begin
              rejects <= '0;
              state <= primed ? S_SUM : S_PRIME;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_PRIME: begin
          for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= absph;
          hidx <= '0; primed <= 1'b1; prev_fp <= absph;
          state <= S_SUM;
        end
        default: ;
      endcase
      // summation sequencing handled below
      if (state == S_PHASE || state == S_PRIME) begin
        sum <= '0; sidx <= '0;
      end
      if (state == S_SUM) begin
        if (sidx == '0) begin
          hist[hidx] <= absph;
          hidx <= (32'(hidx) == HISTORY_DEPTH - 1) ? '0 : hidx + HW'(1);
          sidx <= sidx + 1'b1;
        end else begin
          sum <= sum + SW'(hist[HW'(sidx - 1'b1)]);
          if (32'(sidx) == HISTORY_DEPTH) state <= S_AVG;
          else sidx <= sidx + 1'b1;
        end
      end
      if (state == S_AVG) begin
        fp <= 18'(sum / HISTORY_DEPTH);
        state <= S_MUL;
      end
      if (state == S_MUL) begin
        prod <= $signed({1'b0, gain}) * erw;
        state <= S_STEP;
      end
      if (state == S_STEP) begin
        if (32'(jabs) > 32'(jump)) begin
          wr <= 1'b1; reacq <= 1'b1; locked <= 1'b1; hidx <= '0; primed <= 1'b0;
          cur_f <= fa; dbf <= 1'b0; acc <= {fa, 8'd0}; prev_fp <= 18'(target);
          rejects <= '0;
        end else begin
          prev_fp <= fp;
          dbf <= eabs < 17'(deadband);
          if (eabs < 17'(deadband)) lock_f <= cur_f;
          else if (due) begin
            acc <= acc_c;
            if (nf_step != cur_f) begin cur_f <= nf_step; wr <= 1'b1; end
            last_ms <= now;
          end
        end
        state <= S_OUT;
      end
      if (state == S_OUT) begin
        m_tvalid <= 1'b1;
        state <= S_IDLE;
      end
    end
  end

  assign m_tdata = {3'd0, locked, reacq, lock_f, dbf, ok, last_ph, wr, cur_f};

endmodule
`default_nettype wire

// File: rtl/plft_checker.sv
// Port-level checker for the phase lock frequency tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module plft_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);
  // no new input while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while result pending");
  // accepted item is not ready again next cycle
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after accept");
  // reacquire implies a frequency write and tracking
  a_reacq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[59]) |-> (m_tdata[20] && m_tdata[60]))
    else $error("reacquire without write");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
endmodule

bind phase_lock_frequency_tracker plft_checker u_plft_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire
